// ===== hw/rtl/efq_pkg.sv =====
`default_nettype none
package efq_pkg;

  localparam int unsigned SampleWidth = 24;           // sample width, 17..32
  localparam int unsigned MaxChannels = 64;           // error registers, 1..64
  localparam int unsigned ErrWidth    = SampleWidth + 1;
  localparam int unsigned FracBits    = SampleWidth - 2;
  localparam int unsigned PcmWidth    = 16;
  localparam int unsigned CntWidth    = 7;            // channel_count register
  localparam int unsigned ChanWidth   = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned CfgDataWidth = CntWidth;

  localparam int unsigned InDataWidth  = ((SampleWidth + 7) / 8) * 8;
  localparam int unsigned OutDataWidth = ((PcmWidth + 2 * SampleWidth + 7) / 8) * 8;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgSixteenBit = 1'b0,
    CfgChanCount  = 1'b1
  } cfg_idx_e;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [ErrWidth-1:0]    err_t;

  typedef struct packed {
    logic [PcmWidth-1:0] code;
    err_t                err;
    logic                sat;
  } quant_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/efq_ram.sv =====
`default_nettype none
module efq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/efq_quant.sv =====
`default_nettype none
module efq_quant
  import efq_pkg::*;
(
  input  wire sample_t    sample_i,
  input  wire err_t       err_i,
  input  wire logic       sixteen_i,
  output quant_res_t      res_o
);

  localparam int unsigned CW  = SampleWidth + 2;   // corrected value
  localparam int unsigned DW  = CW + 1;            // new error before saturation
  localparam int unsigned K16 = FracBits - 15;
  localparam int unsigned K8  = FracBits - 7;
  localparam int unsigned KW  = $clog2(K8 + 1);

  localparam logic signed [CW-1:0] Top16 = CW'(32767);
  localparam logic signed [CW-1:0] Bot16 = -CW'(32768);
  localparam logic signed [CW-1:0] Top8  = CW'(127);
  localparam logic signed [CW-1:0] Bot8  = -CW'(128);
  localparam logic signed [DW-1:0] EMax  = DW'((64'd1 << SampleWidth) - 64'd1);
  localparam logic signed [DW-1:0] EMin  = -EMax - DW'(1);

  logic signed [CW-1:0] corr;
  logic        [KW-1:0] k;
  logic signed [CW-1:0] top, bot, top_s, bot_s;
  logic        [CW-1:0] frac_mask;
  logic signed [CW-1:0] q_trunc, q_sel, q_val;
  logic                 hi, lo;
  logic signed [DW-1:0] err_full;

  always_comb begin
    corr = CW'(sample_i) - CW'(err_i);
    k    = sixteen_i ? KW'(K16) : KW'(K8);
    top  = sixteen_i ? Top16 : Top8;
    bot  = sixteen_i ? Bot16 : Bot8;
    top_s = top <<< k;
    bot_s = bot <<< k;
    hi = corr > top_s;
    lo = corr < bot_s;

    // truncate toward zero: floor shift, then bump negatives with a remainder
    frac_mask = (CW'(1) << k) - CW'(1);
    q_trunc   = (corr >>> k)
              + $signed(CW'(corr[CW-1] && ((corr & frac_mask) != '0)));

    priority if (hi) begin
      q_sel = top;
    end else if (lo) begin
      q_sel = bot;
    end else begin
      q_sel = q_trunc;
    end
    q_val = q_sel <<< k;

    err_full = DW'(q_val) - DW'(corr);
    priority if (err_full > EMax) begin
      res_o.err = ErrWidth'(EMax);
    end else if (err_full < EMin) begin
      res_o.err = ErrWidth'(EMin);
    end else begin
      res_o.err = err_full[ErrWidth-1:0];
    end

    res_o.sat  = hi | lo;
    res_o.code = sixteen_i ? q_sel[PcmWidth-1:0]
                           : {8'h00, q_sel[7:0] ^ 8'h80};
  end

endmodule
`default_nettype wire

// ===== hw/rtl/error_feedback_pcm_quantizer_unit.sv =====
`default_nettype none
// Pipeline: the input register loads at the input accept edge, the result register when
//   the result slot is free; m_axis_tvalid then shows the result.
// Throughput: one item per clock unless the result stalls; the channel error table is
//   read from its RAM at accept time, ahead of use, with a bypass for the item just ahead.
// Reset: clears channel counter, clip flag, extremes, config (16-bit mode, one channel)
//   and the per-channel valid bits, so every channel error reads as zero; no clearing pass.
module error_feedback_pcm_quantizer_unit
  import efq_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // input items
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [InDataWidth-1:0]  s_axis_tdata,   // sample_in
  input  wire logic                    s_axis_tuser,   // clear_clip_first
  // result items
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [OutDataWidth-1:0]      m_axis_tdata,   // pcm_code, min_seen, max_seen
  output logic                         m_axis_tuser,   // clip_sticky
  output logic                         m_axis_tlast,   // frame_last
  // configuration
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i
);

  // config registers
  logic                sixteen_q;
  logic [CntWidth-1:0] count_q;
  logic [CntWidth-1:0] count_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sixteen_q <= 1'b1;
      count_q   <= CntWidth'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgSixteenBit: sixteen_q <= cfg_data_i[0];
        CfgChanCount:  count_q   <= cfg_data_i[CntWidth-1:0];
        default: ;
      endcase
    end
  end

  // zero means one channel, anything above the table size saturates
  always_comb begin
    priority if (count_q == '0) begin
      count_eff = CntWidth'(1);
    end else if (count_q > CntWidth'(MaxChannels)) begin
      count_eff = CntWidth'(MaxChannels);
    end else begin
      count_eff = count_q;
    end
  end

  // handshake / pipeline control
  logic s1_valid_q, out_valid_q;
  logic s1_adv, in_acc;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // channel counter
  logic [ChanWidth-1:0] chan_q;
  logic                 last_d;

  assign last_d = (CntWidth'(chan_q) + CntWidth'(1)) >= count_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
    end else if (in_acc) begin
      chan_q <= last_d ? '0 : chan_q + ChanWidth'(1);
    end
  end

  // input register
  sample_t              s1_sample_q;
  logic                 s1_clr_q;
  logic                 s1_last_q;
  logic [ChanWidth-1:0] s1_idx_q;
  logic                 s1_fwd_q;
  err_t                 s1_fwd_err_q;
  logic                 s1_err_vld_q;
  logic [MaxChannels-1:0] err_vld_q;

  quant_res_t qres;
  err_t       ram_rdata;
  err_t       err_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q  <= s_axis_tdata[SampleWidth-1:0];
      s1_clr_q     <= s_axis_tuser;
      s1_last_q    <= last_d;
      s1_idx_q     <= chan_q;
      s1_err_vld_q <= err_vld_q[chan_q];
      // the item ahead writes its error at this same edge: take it directly
      s1_fwd_q     <= s1_adv && (s1_idx_q == chan_q);
      s1_fwd_err_q <= qres.err;
    end
  end

  // error table, valid bit per channel stands in for the reset clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_vld_q <= '0;
    end else if (s1_adv) begin
      err_vld_q[s1_idx_q] <= 1'b1;
    end
  end

  efq_ram #(
    .Width (ErrWidth),
    .Depth (MaxChannels)
  ) u_err_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_idx_q),
    .wdata_i (qres.err),
    .re_i    (in_acc),
    .raddr_i (chan_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    priority if (s1_fwd_q) begin
      err_use = s1_fwd_err_q;
    end else if (s1_err_vld_q) begin
      err_use = ram_rdata;
    end else begin
      err_use = '0;
    end
  end

  efq_quant u_quant (
    .sample_i  (s1_sample_q),
    .err_i     (err_use),
    .sixteen_i (sixteen_q),
    .res_o     (qres)
  );

  // result register; clip and extremes are block state that the result shows directly
  logic [PcmWidth-1:0] code_q;
  logic                last_q;
  logic                clip_q;
  sample_t             min_q, max_q;
  logic                ext_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      clip_q      <= 1'b0;
      min_q       <= '0;
      max_q       <= '0;
      ext_vld_q   <= 1'b0;
    end else begin
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        clip_q    <= (clip_q && !s1_clr_q) || qres.sat;
        ext_vld_q <= 1'b1;
        if (!ext_vld_q || (s1_sample_q < min_q)) begin
          min_q <= s1_sample_q;
        end
        if (!ext_vld_q || (s1_sample_q > max_q)) begin
          max_q <= s1_sample_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      code_q <= qres.code;
      last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataWidth'({max_q, min_q, code_q});
  assign m_axis_tuser  = clip_q;
  assign m_axis_tlast  = last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/efq_checker.sv =====
`default_nettype none
module efq_checker
  import efq_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    s_axis_tvalid,
  input wire logic                    s_axis_tready,
  input wire logic                    m_axis_tvalid,
  input wire logic                    m_axis_tready,
  input wire logic [OutDataWidth-1:0] m_axis_tdata,
  input wire logic                    m_axis_tuser,
  input wire logic                    m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("result changed while stalled");

  // with the result slot empty the block never backs up its input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result slot");

  // extremes stay ordered
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[PcmWidth+SampleWidth-1:PcmWidth])
       <= $signed(m_axis_tdata[PcmWidth+2*SampleWidth-1:PcmWidth+SampleWidth])))
    else $error("min_seen above max_seen");

  // nothing comes out without an item having gone in earlier or being held
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(m_axis_tvalid)) |-> $past(s_axis_tvalid && s_axis_tready, 2)
      || $past(s_axis_tvalid && s_axis_tready, 3) || $past(m_axis_tvalid, 2))
    else $error("result without input");

endmodule

bind error_feedback_pcm_quantizer_unit efq_checker u_efq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
